>>> rtl/core/tdet_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the table-driven event timer state machine.
// No dependencies; used by the controller, the datapath and the top level.
package tdet_pkg;

   localparam int STATE_BITS  = 4;
   localparam int STATE_COUNT = 16;
   localparam int ENTRIES     = 16;
   localparam int IDX_BITS    = 4;
   localparam int CNT_BITS    = 5;
   localparam int TIME_BITS   = 32;

   // operation codes of an input beat
   localparam logic [2:0] OP_EVENT    = 3'd0;
   localparam logic [2:0] OP_TICK     = 3'd1;
   localparam logic [2:0] OP_WRITE_EV = 3'd2;
   localparam logic [2:0] OP_WRITE_TM = 3'd3;
   localparam logic [2:0] OP_RESTART  = 3'd4;

   // configuration register indexes
   localparam logic [2:0] CSR_INITIAL  = 3'd0;
   localparam logic [2:0] CSR_EV_COUNT = 3'd1;
   localparam logic [2:0] CSR_TM_COUNT = 3'd2;
   localparam logic [2:0] CSR_FINAL    = 3'd3;
   localparam logic [2:0] CSR_RUN_IVAL = 3'd4;

   typedef struct packed {
      logic capture;
      logic write_ev;
      logic write_tm;
      logic restart;
      logic enter_init;
      logic enter_target;
      logic tick_run;
      logic ev_fire;
      logic tm_arm;
      logic tm_fire;
      logic idx_inc;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       started;
      logic       finished;
      logic       tick_ok;
      logic       ev_end;
      logic       tm_end;
      logic       ev_match;
      logic       tm_applies;
      logic       tm_idle;
      logic       tm_expired;
      logic       guard;
   } status_type;

endpackage

>>> rtl/core/tdet_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the event timer state machine: dispatch, table scans, entry.
// Depends on tdet_pkg for the command and status structs.
module tdet_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  tdet_pkg::status_type sts,
   output tdet_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_TKCHK    = 3'd2;
   localparam logic [2:0] S_EVSCAN   = 3'd3;
   localparam logic [2:0] S_TMSCAN   = 3'd4;
   localparam logic [2:0] S_ENTER    = 3'd5;
   localparam logic [2:0] S_DONE     = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_DONE;
            case (sts.op)
               tdet_pkg::OP_EVENT: begin
                  cmd.enter_init = !sts.started;
                  state_in       = S_EVSCAN;
               end
               tdet_pkg::OP_TICK: begin
                  cmd.enter_init = !sts.started;
                  state_in       = S_TKCHK;
               end
               tdet_pkg::OP_WRITE_EV: cmd.write_ev = 1'b1;
               tdet_pkg::OP_WRITE_TM: cmd.write_tm = 1'b1;
               tdet_pkg::OP_RESTART:  cmd.restart  = 1'b1;
               default: ;
            endcase
         end
         S_TKCHK: begin
            if (!sts.finished && sts.tick_ok) begin
               cmd.tick_run = 1'b1;
               state_in     = S_TMSCAN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_EVSCAN: begin
            if (sts.ev_end) begin
               state_in = S_DONE;
            end else if (sts.ev_match) begin
               if (sts.guard) begin
                  cmd.ev_fire = 1'b1;
                  state_in    = S_ENTER;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_TMSCAN: begin
            if (sts.tm_end) begin
               state_in = S_DONE;
            end else if (sts.tm_applies && sts.tm_idle) begin
               cmd.tm_arm  = 1'b1;
               cmd.idx_inc = 1'b1;
            end else if (sts.tm_applies && sts.tm_expired && sts.guard) begin
               cmd.tm_fire = 1'b1;
               state_in    = S_ENTER;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_ENTER: begin
            cmd.enter_target = 1'b1;
            state_in         = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold the result beat until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/tdet_dp.sv
`timescale 1ns / 1ps
// Datapath: configuration, transition tables, timers, machine state, result.
// Depends on tdet_pkg; driven by commands from tdet_ctrl.
module tdet_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  tdet_pkg::cmd_type    cmd,
   output tdet_pkg::status_type sts,
   input  logic                 csr_write,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_data,
   input  logic [2:0]           req_operation,
   input  logic [31:0]          req_now_ms,
   input  logic [7:0]           req_event_id,
   input  logic [3:0]           req_entry_index,
   input  logic                 req_entry_global,
   input  logic [3:0]           req_entry_from,
   input  logic [3:0]           req_entry_to,
   input  logic [31:0]          req_entry_interval,
   input  logic [15:0]          req_guard_mask,
   output logic                 rsp_fired,
   output logic [3:0]           rsp_taken_entry,
   output logic [3:0]           rsp_state_now,
   output logic [3:0]           rsp_state_left,
   output logic                 rsp_entered_initial,
   output logic                 rsp_state_tick,
   output logic                 rsp_finished
);

   localparam int SB = tdet_pkg::STATE_BITS;
   localparam int TB = tdet_pkg::TIME_BITS;
   localparam int CB = tdet_pkg::CNT_BITS;
   localparam int IB = tdet_pkg::IDX_BITS;
   localparam int NE = tdet_pkg::ENTRIES;
   localparam logic [CB-1:0] DEPTH = CB'(NE);

   // configuration
   logic [SB-1:0] init_ff;
   logic [CB-1:0] ev_cnt_ff, tm_cnt_ff;
   logic [15:0]   final_ff, run_ival_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff     <= '0;
         ev_cnt_ff   <= '0;
         tm_cnt_ff   <= '0;
         final_ff    <= '0;
         run_ival_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            tdet_pkg::CSR_INITIAL:  init_ff     <= csr_data[SB-1:0];
            tdet_pkg::CSR_EV_COUNT: ev_cnt_ff   <= csr_data[CB-1:0];
            tdet_pkg::CSR_TM_COUNT: tm_cnt_ff   <= csr_data[CB-1:0];
            tdet_pkg::CSR_FINAL:    final_ff    <= csr_data;
            tdet_pkg::CSR_RUN_IVAL: run_ival_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // captured input beat
   logic [2:0]    op_ff;
   logic [TB-1:0] now_ff, ival_ff;
   logic [7:0]    eid_ff;
   logic [IB-1:0] widx_ff;
   logic          glob_ff;
   logic [SB-1:0] from_ff, to_ff;
   logic [15:0]   guard_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_operation;
         now_ff   <= req_now_ms;
         eid_ff   <= req_event_id;
         widx_ff  <= req_entry_index;
         glob_ff  <= req_entry_global;
         from_ff  <= req_entry_from;
         to_ff    <= req_entry_to;
         ival_ff  <= req_entry_interval;
         guard_ff <= req_guard_mask;
      end
   end

   // tables, no reset
   logic          ev_glob_ff [NE];
   logic [SB-1:0] ev_from_ff [NE];
   logic [SB-1:0] ev_to_ff   [NE];
   logic [7:0]    ev_id_ff   [NE];
   logic          tm_glob_ff [NE];
   logic [SB-1:0] tm_from_ff [NE];
   logic [SB-1:0] tm_to_ff   [NE];
   logic [TB-1:0] tm_ival_ff [NE];

   always_ff @(posedge clock) begin
      if (cmd.write_ev) begin
         ev_glob_ff[widx_ff] <= glob_ff;
         ev_from_ff[widx_ff] <= from_ff;
         ev_to_ff[widx_ff]   <= to_ff;
         ev_id_ff[widx_ff]   <= eid_ff;
      end
      if (cmd.write_tm) begin
         tm_glob_ff[widx_ff] <= glob_ff;
         tm_from_ff[widx_ff] <= from_ff;
         tm_to_ff[widx_ff]   <= to_ff;
         tm_ival_ff[widx_ff] <= ival_ff;
      end
   end

   // machine state and scan bookkeeping
   logic          started_ff, finished_ff;
   logic [SB-1:0] cur_ff, target_ff;
   logic [TB-1:0] last_run_ff;
   logic [TB-1:0] timer_ff [NE];
   logic [CB-1:0] idx_ff;
   logic [IB-1:0] idx;
   logic          fired_ff, entered_ff, tick_ff;
   logic [IB-1:0] taken_ff;
   logic [SB-1:0] left_ff;
   logic          do_enter;
   logic [SB-1:0] enter_state;
   logic [CB-1:0] ev_used, tm_used;

   assign idx         = idx_ff[IB-1:0];
   assign do_enter    = cmd.enter_init || cmd.enter_target;
   assign enter_state = cmd.enter_init ? init_ff : target_ff;
   assign ev_used     = (ev_cnt_ff > DEPTH) ? DEPTH : ev_cnt_ff;
   assign tm_used     = (tm_cnt_ff > DEPTH) ? DEPTH : tm_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         started_ff  <= 1'b0;
         finished_ff <= 1'b0;
         cur_ff      <= '0;
         last_run_ff <= '0;
         for (int i = 0; i < NE; i++) timer_ff[i] <= '0;
      end else begin
         if (do_enter) begin
            cur_ff      <= enter_state;
            last_run_ff <= now_ff;
            if (final_ff[enter_state]) finished_ff <= 1'b1;
            // clear timers of entries leaving the new state
            for (int i = 0; i < NE; i++) begin
               if (CB'(i) < tm_used && (tm_glob_ff[i] || tm_from_ff[i] == enter_state))
                  timer_ff[i] <= '0;
            end
         end
         if (cmd.enter_init) started_ff <= 1'b1;
         if (cmd.tick_run) last_run_ff <= now_ff;
         if (cmd.tm_arm) timer_ff[idx] <= now_ff;
         if (cmd.tm_fire) timer_ff[idx] <= '0;
         if (cmd.write_tm) timer_ff[widx_ff] <= '0;
      end
   end

   // scan index and per-beat result flags
   always_ff @(posedge clock) begin
      if (cmd.capture || cmd.tick_run) idx_ff <= '0;
      else if (cmd.idx_inc) idx_ff <= idx_ff + CB'(1);
      if (cmd.capture) begin
         fired_ff   <= 1'b0;
         entered_ff <= 1'b0;
         tick_ff    <= 1'b0;
         taken_ff   <= '0;
         left_ff    <= '0;
      end else begin
         if (cmd.enter_init) entered_ff <= 1'b1;
         if (cmd.tick_run) tick_ff <= 1'b1;
         if (cmd.ev_fire || cmd.tm_fire) begin
            fired_ff <= 1'b1;
            taken_ff <= idx;
            left_ff  <= cur_ff;
         end
      end
      if (cmd.ev_fire) target_ff <= ev_to_ff[idx];
      if (cmd.tm_fire) target_ff <= tm_to_ff[idx];
   end

   // status toward the sequencer
   logic [TB-1:0] run_diff, tm_diff;
   assign run_diff = now_ff - last_run_ff;
   assign tm_diff  = now_ff - timer_ff[idx];

   always_comb begin
      sts.op         = op_ff;
      sts.started    = started_ff;
      sts.finished   = finished_ff;
      sts.tick_ok    = run_diff >= TB'(run_ival_ff);
      sts.ev_end     = !(idx_ff < ev_used);
      sts.tm_end     = !(idx_ff < tm_used);
      sts.ev_match   = (ev_glob_ff[idx] || ev_from_ff[idx] == cur_ff) &&
                       ev_id_ff[idx] == eid_ff;
      sts.tm_applies = tm_glob_ff[idx] || tm_from_ff[idx] == cur_ff;
      sts.tm_idle    = timer_ff[idx] == '0;
      sts.tm_expired = tm_diff >= tm_ival_ff[idx];
      sts.guard      = guard_ff[idx];
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_fired           <= fired_ff;
         rsp_taken_entry     <= taken_ff;
         rsp_state_now       <= cur_ff;
         rsp_state_left      <= left_ff;
         rsp_entered_initial <= entered_ff;
         rsp_state_tick      <= tick_ff;
         rsp_finished        <= finished_ff;
      end
   end

endmodule

>>> rtl/core/table_driven_event_timer_fsm.sv
`timescale 1ns / 1ps
// Table-driven state machine with event and timed transition tables.
// Writes and restart run dispatch and the result load; an event or tick adds
// a scan of its table entry by entry before the load, and entry on a transition.
// Throughput: one beat at a time; the next beat is accepted once the result
// sits in the output register. Reset (synchronous) clears state and config.
module table_driven_event_timer_fsm (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_now_ms,
   input  logic [7:0]  req_event_id,
   input  logic [3:0]  req_entry_index,
   input  logic        req_entry_global,
   input  logic [3:0]  req_entry_from,
   input  logic [3:0]  req_entry_to,
   input  logic [31:0] req_entry_interval,
   input  logic [15:0] req_guard_mask,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_fired,
   output logic [3:0]  rsp_taken_entry,
   output logic [3:0]  rsp_state_now,
   output logic [3:0]  rsp_state_left,
   output logic        rsp_entered_initial,
   output logic        rsp_state_tick,
   output logic        rsp_finished,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   tdet_pkg::cmd_type    cmd;
   tdet_pkg::status_type sts;

   assign csr_ready = 1'b1;

   tdet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tdet_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .csr_write           (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_operation       (req_operation),
      .req_now_ms          (req_now_ms),
      .req_event_id        (req_event_id),
      .req_entry_index     (req_entry_index),
      .req_entry_global    (req_entry_global),
      .req_entry_from      (req_entry_from),
      .req_entry_to        (req_entry_to),
      .req_entry_interval  (req_entry_interval),
      .req_guard_mask      (req_guard_mask),
      .rsp_fired           (rsp_fired),
      .rsp_taken_entry     (rsp_taken_entry),
      .rsp_state_now       (rsp_state_now),
      .rsp_state_left      (rsp_state_left),
      .rsp_entered_initial (rsp_entered_initial),
      .rsp_state_tick      (rsp_state_tick),
      .rsp_finished        (rsp_finished)
   );

   // an accepted beat keeps the input stalled while it is worked on
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after accepted beat");

   // a nonzero taken entry only comes with a transition
   a_taken_fired: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_taken_entry != 4'd0 |-> rsp_fired)
      else $error("taken entry without transition");

   // the result register loads only when the slot is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !rsp_valid || !rsp_stall)
      else $error("result overwritten while stalled");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for table_driven_event_timer_fsm: loads both tables,
// runs directed and random beats under several idle mixes and checks each result.
// Depends on tdet_pkg and the top level only.
module testbench;

   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int         SETTLE     = 30;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] now_ms;
      logic [7:0]  ev_num;
      logic [3:0]  index;
      logic        any_state;
      logic [3:0]  from;
      logic [3:0]  to;
      logic [31:0] interval;
      logic [15:0] guards;
   } beat_type;

   typedef struct packed {
      logic       fired;
      logic [3:0] taken_entry;
      logic [3:0] state_now;
      logic [3:0] state_left;
      logic       entered_initial;
      logic       state_tick;
      logic       finished;
   } outcome_type;

   typedef struct packed {
      logic       any_state;
      logic [3:0] from;
      logic [3:0] to;
      logic [7:0] id;
   } ev_slot_type;

   typedef struct packed {
      logic        any_state;
      logic [3:0]  from;
      logic [3:0]  to;
      logic [31:0] interval;
   } tm_slot_type;

   logic        clock, reset;
   logic        req_valid, req_stall;
   logic [2:0]  req_operation;
   logic [31:0] req_now_ms, req_entry_interval;
   logic [7:0]  req_event_id;
   logic [3:0]  req_entry_index, req_entry_from, req_entry_to;
   logic        req_entry_global;
   logic [15:0] req_guard_mask;
   logic        rsp_valid, rsp_stall;
   logic        rsp_fired, rsp_entered_initial, rsp_state_tick, rsp_finished;
   logic [3:0]  rsp_taken_entry, rsp_state_now, rsp_state_left;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   // shadow machine state and registers
   logic [3:0]  init_state;
   logic [4:0]  ev_count, tm_count;
   logic [15:0] final_states, run_gap;
   logic        m_started, m_finished;
   logic [3:0]  m_state, m_prev;
   logic [31:0] m_last_run, m_last_change;
   ev_slot_type ev_slots [16];
   tm_slot_type tm_slots [16];
   logic [31:0] timer_at [16];

   outcome_type expected_outcomes[$];
   int          fail_count = 0;
   int          sender_idle_pct = 0;
   int          stall_pct = 0;
   logic [31:0] clock_ms = 0;

   table_driven_event_timer_fsm dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hold off results at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // compare each result beat with the oldest prediction
   always @(posedge clock) begin
      outcome_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_fired, rsp_taken_entry, rsp_state_now, rsp_state_left,
                 rsp_entered_initial, rsp_state_tick, rsp_finished};
         if (expected_outcomes.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            fail_count++;
         end else begin
            want = expected_outcomes.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected %p actual %p", $time, want, got);
               fail_count++;
            end
         end
      end
   end

   function automatic int slots_used(logic [4:0] cnt);
      return (cnt > 16) ? 16 : int'(cnt);
   endfunction

   function automatic void enter_state(logic [3:0] s, logic [31:0] now);
      int n;
      n = slots_used(tm_count);
      m_prev = m_state;
      m_state = s;
      m_last_run = now;
      m_last_change = now;
      for (int i = 0; i < n; i++)
         if (tm_slots[i].any_state || tm_slots[i].from == s) timer_at[i] = '0;
      if (final_states[s]) m_finished = 1'b1;
   endfunction

   function automatic void clear_run();
      m_started = 1'b0;
      m_finished = 1'b0;
      m_state = '0;
      m_prev = '0;
      m_last_run = '0;
      m_last_change = '0;
      foreach (timer_at[i]) timer_at[i] = '0;
   endfunction

   // advance the shadow machine by one beat and return its result
   function automatic outcome_type advance_machine(beat_type b);
      outcome_type o;
      int          n;
      bit          done;
      o = '0;
      done = 0;
      if ((b.op == tdet_pkg::OP_EVENT || b.op == tdet_pkg::OP_TICK) && !m_started) begin
         m_started = 1'b1;
         enter_state(init_state, b.now_ms);
         o.entered_initial = 1'b1;
      end
      case (b.op)
         tdet_pkg::OP_EVENT: begin
            n = slots_used(ev_count);
            for (int i = 0; i < n && !done; i++) begin
               if ((ev_slots[i].any_state || ev_slots[i].from == m_state) &&
                   ev_slots[i].id == b.ev_num) begin
                  done = 1;
                  if (b.guards[i]) begin
                     o.fired = 1'b1;
                     o.taken_entry = i[3:0];
                     o.state_left = m_state;
                     enter_state(ev_slots[i].to, b.now_ms);
                  end
               end
            end
         end
         tdet_pkg::OP_TICK: begin
            if (!m_finished && (b.now_ms - m_last_run) >= {16'd0, run_gap}) begin
               m_last_run = b.now_ms;
               n = slots_used(tm_count);
               for (int i = 0; i < n && !done; i++) begin
                  if (tm_slots[i].any_state || tm_slots[i].from == m_state) begin
                     if (timer_at[i] == 0) begin
                        timer_at[i] = b.now_ms;
                     end else if ((b.now_ms - timer_at[i]) >= tm_slots[i].interval &&
                                  b.guards[i]) begin
                        o.fired = 1'b1;
                        o.taken_entry = i[3:0];
                        o.state_left = m_state;
                        enter_state(tm_slots[i].to, b.now_ms);
                        timer_at[i] = '0;
                        done = 1;
                     end
                  end
               end
               o.state_tick = 1'b1;
            end
         end
         tdet_pkg::OP_WRITE_EV: begin
            ev_slots[b.index] = '{b.any_state, b.from, b.to, b.ev_num};
         end
         tdet_pkg::OP_WRITE_TM: begin
            tm_slots[b.index] = '{b.any_state, b.from, b.to, b.interval};
            timer_at[b.index] = '0;
         end
         tdet_pkg::OP_RESTART: clear_run();
         default: ;
      endcase
      o.state_now = m_state;
      o.finished = m_finished;
      return o;
   endfunction

   // present one beat, hold it until accepted, then maybe idle
   task automatic send_beat(beat_type b);
      req_valid          <= 1'b1;
      req_operation      <= b.op;
      req_now_ms         <= b.now_ms;
      req_event_id       <= b.ev_num;
      req_entry_index    <= b.index;
      req_entry_global   <= b.any_state;
      req_entry_from     <= b.from;
      req_entry_to       <= b.to;
      req_entry_interval <= b.interval;
      req_guard_mask     <= b.guards;
      do @(posedge clock); while (req_stall);
      expected_outcomes.push_back(advance_machine(b));
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // write one register while the block is idle
   task automatic write_csr(logic [2:0] idx, logic [15:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         tdet_pkg::CSR_INITIAL:  init_state = value[3:0];
         tdet_pkg::CSR_EV_COUNT: ev_count = value[4:0];
         tdet_pkg::CSR_TM_COUNT: tm_count = value[4:0];
         tdet_pkg::CSR_FINAL:    final_states = value;
         tdet_pkg::CSR_RUN_IVAL: run_gap = value;
         default: ;
      endcase
   endtask

   function automatic beat_type op_beat(logic [2:0] op, logic [31:0] now,
                                        logic [7:0] id, logic [15:0] guards);
      beat_type b;
      b = '0;
      b.op = op;
      b.now_ms = now;
      b.ev_num = id;
      b.guards = guards;
      b.index = 4'($urandom());
      b.any_state = 1'($urandom());
      b.from = 4'($urandom());
      b.to = 4'($urandom());
      b.interval = $urandom();
      return b;
   endfunction

   function automatic beat_type table_beat(logic [2:0] op, logic [3:0] idx);
      beat_type b;
      b = op_beat(op, $urandom(), 8'($urandom_range(3)), 16'($urandom()));
      b.index = idx;
      b.any_state = ($urandom_range(5) == 0);
      b.from = 4'($urandom_range(3));
      b.to = ($urandom_range(7) == 0) ? 4'($urandom()) : 4'($urandom_range(3));
      b.interval = ($urandom_range(15) == 0) ? 32'($urandom()) | 32'd1
                                             : 32'($urandom_range(1, 60));
      return b;
   endfunction

   // mostly well-formed traffic over clustered states and event numbers
   function automatic beat_type random_beat();
      int       pick;
      beat_type b;
      pick = $urandom_range(99);
      if (pick < 40 || pick >= 60) clock_ms = clock_ms + $urandom_range(0, 25);
      if (pick < 40)
         b = op_beat(tdet_pkg::OP_EVENT, clock_ms,
                     ($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(3)),
                     ($urandom_range(3) == 0) ? 16'($urandom()) : 16'hFFFF);
      else if (pick < 75)
         b = op_beat(tdet_pkg::OP_TICK, clock_ms, 8'($urandom()),
                     ($urandom_range(3) == 0) ? 16'($urandom()) : 16'hFFFF);
      else if (pick < 83) b = table_beat(tdet_pkg::OP_WRITE_EV, 4'($urandom()));
      else if (pick < 90) b = table_beat(tdet_pkg::OP_WRITE_TM, 4'($urandom()));
      else if (pick < 97)
         b = op_beat(tdet_pkg::OP_RESTART, clock_ms, 8'($urandom()), 16'($urandom()));
      else b = op_beat(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), $urandom(),
                       8'($urandom()), 16'($urandom()));
      return b;
   endfunction

   // fill every slot of both tables before any slot is put in use
   task automatic test_table_load();
      for (int i = 0; i < 16; i++) send_beat(table_beat(tdet_pkg::OP_WRITE_EV, i[3:0]));
      for (int i = 0; i < 16; i++) send_beat(table_beat(tdet_pkg::OP_WRITE_TM, i[3:0]));
   endtask

   // field extremes, every operation and the corner cases
   task automatic test_directed();
      beat_type b;
      write_csr(tdet_pkg::CSR_INITIAL, 16'd15);
      write_csr(tdet_pkg::CSR_EV_COUNT, 16'd16);
      write_csr(tdet_pkg::CSR_TM_COUNT, 16'd31);
      write_csr(tdet_pkg::CSR_FINAL, 16'h0000);
      write_csr(tdet_pkg::CSR_RUN_IVAL, 16'd0);
      b = table_beat(tdet_pkg::OP_WRITE_EV, 4'd15);
      b.ev_num = 8'hFF;
      b.any_state = 1'b1;
      b.from = 4'd15;
      b.to = 4'd0;
      send_beat(b);
      b = table_beat(tdet_pkg::OP_WRITE_TM, 4'd15);
      b.interval = 32'hFFFF_FFFF;
      b.any_state = 1'b1;
      b.to = 4'd15;
      send_beat(b);
      // first tick at time zero enters the initial state; arming at zero stays idle
      send_beat(op_beat(tdet_pkg::OP_TICK, 32'd0, 8'd0, 16'hFFFF));
      send_beat(op_beat(tdet_pkg::OP_TICK, 32'd0, 8'd0, 16'hFFFF));
      send_beat(op_beat(tdet_pkg::OP_TICK, 32'd5, 8'd0, 16'hFFFF));
      send_beat(op_beat(tdet_pkg::OP_TICK, 32'hFFFF_FFF0, 8'd0, 16'hFFFF));
      send_beat(op_beat(tdet_pkg::OP_TICK, 32'd20, 8'd0, 16'hFFFF));
      // blocked guard, unmatched event, global entry
      send_beat(op_beat(tdet_pkg::OP_EVENT, 32'd30, 8'hFF, 16'h0000));
      send_beat(op_beat(tdet_pkg::OP_EVENT, 32'd31, 8'd200, 16'hFFFF));
      send_beat(op_beat(tdet_pkg::OP_EVENT, 32'd32, 8'hFF, 16'hFFFF));
      for (int k = int'(OP_SPARE_LO); k <= int'(OP_SPARE_HI); k++)
         send_beat(op_beat(3'(k), 32'hFFFF_FFFF, 8'hFF, 16'hFFFF));
      send_beat(op_beat(tdet_pkg::OP_RESTART, 32'd0, 8'd0, 16'd0));
      // first event after restart, then finish and check ticks stop but events move
      write_csr(tdet_pkg::CSR_FINAL, 16'hFFFF);
      send_beat(op_beat(tdet_pkg::OP_EVENT, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF));
      send_beat(op_beat(tdet_pkg::OP_TICK, 32'd100, 8'd0, 16'hFFFF));
      send_beat(op_beat(tdet_pkg::OP_EVENT, 32'd101, 8'hFF, 16'hFFFF));
      send_beat(op_beat(tdet_pkg::OP_RESTART, 32'd0, 8'd0, 16'd0));
      // first tick with a nonzero run interval does not act
      write_csr(tdet_pkg::CSR_RUN_IVAL, 16'hFFFF);
      write_csr(tdet_pkg::CSR_FINAL, 16'h0000);
      send_beat(op_beat(tdet_pkg::OP_TICK, 32'd7, 8'd0, 16'hFFFF));
      send_beat(op_beat(tdet_pkg::OP_TICK, 32'd8, 8'd0, 16'hFFFF));
      send_beat(op_beat(tdet_pkg::OP_TICK, 32'h0001_0006, 8'd0, 16'hFFFF));
      send_beat(op_beat(tdet_pkg::OP_RESTART, 32'd0, 8'd0, 16'd0));
   endtask

   // one random phase under a given configuration and idle mix
   task automatic test_random(int idle_pct, int hold_pct, logic [3:0] init,
                              logic [4:0] evs, logic [4:0] tms,
                              logic [15:0] finals, logic [15:0] gap, int beats);
      write_csr(tdet_pkg::CSR_INITIAL, {12'd0, init});
      write_csr(tdet_pkg::CSR_EV_COUNT, {11'd0, evs});
      write_csr(tdet_pkg::CSR_TM_COUNT, {11'd0, tms});
      write_csr(tdet_pkg::CSR_FINAL, finals);
      write_csr(tdet_pkg::CSR_RUN_IVAL, gap);
      sender_idle_pct = idle_pct;
      stall_pct = hold_pct;
      for (int i = 0; i < beats; i++) send_beat(random_beat());
   endtask

   // send only once every outstanding result has come back
   task automatic test_pause_drained();
      for (int i = 0; i < 6; i++) begin
         drain();
         send_beat(random_beat());
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_operation      <= tdet_pkg::OP_EVENT;
      req_now_ms         <= '0;
      req_event_id       <= '0;
      req_entry_index    <= '0;
      req_entry_global   <= 1'b0;
      req_entry_from     <= '0;
      req_entry_to       <= '0;
      req_entry_interval <= '0;
      req_guard_mask     <= '0;
      rsp_stall          <= 1'b0;
      csr_valid          <= 1'b0;
      csr_index          <= tdet_pkg::CSR_INITIAL;
      csr_data           <= '0;
      init_state = '0;
      ev_count = '0;
      tm_count = '0;
      final_states = '0;
      run_gap = '0;
      foreach (ev_slots[i]) ev_slots[i] = '0;
      foreach (tm_slots[i]) tm_slots[i] = '0;
      clear_run();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_table_load();
      test_directed();
      test_random(0, 0, 4'd0, 5'd16, 5'd16, 16'h0000, 16'd0, 100);
      test_random(52, 0, 4'($urandom_range(3)), 5'($urandom_range(16)),
                  5'($urandom_range(16)), 16'h0008, 16'd3, 100);
      test_pause_drained();
      test_random(0, 52, 4'd1, 5'd8, 5'd16, 16'($urandom()) & 16'hFFF0, 16'd0, 100);
      test_random(32, 32, 4'd2, 5'd16, 5'd4, 16'h8000, 16'd10, 100);
      test_random(0, 0, 4'd3, 5'd0, 5'd0, 16'hFFFF, 16'hFFFF, 10);

      drain();
      if (fail_count == 0)
         $display("table_driven_event_timer_fsm verification clean");
      else
         $display("table_driven_event_timer_fsm verification failed");
      $finish;
   end

   // give up on a hang
   initial begin
      #1_000_000;
      $display("table_driven_event_timer_fsm verification failed");
      $finish;
   end

endmodule
